/* rtl/cas_pkg.sv */
// ----------------------------------------------------------------------------
// cas_pkg
// Shared types, register codes and helpers for the cumulative sum block.
// ----------------------------------------------------------------------------
package cas_pkg;

  // element and port widths
  localparam int DATA_W      = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int INNER_W     = 11;
  localparam int AXIS_LEN_W  = 17;
  localparam int AXIS_POS_W  = 16;
  localparam int AXIS_MAX    = 65536;
  localparam int MAX_INNER_DEF = 1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXCL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS  = 2'd3;

  // element width codes
  localparam logic [1:0] EW_8  = 2'd0;
  localparam logic [1:0] EW_16 = 2'd1;
  localparam logic [1:0] EW_32 = 2'd2;
  localparam logic [1:0] EW_64 = 2'd3;

  // control from the top level to the accumulate stage
  typedef struct packed {
    logic take;   // item accepted this cycle
    logic first;  // item sits at axis position zero
  } acc_ctl_t;

  // status from the accumulate stage
  typedef struct packed {
    logic busy;   // stage one holds an item
    logic stall;  // stage one cannot take a new item
    logic wr_en;  // running sum written this cycle
  } acc_sts_t;

  // keep the low bits of the selected element width
  function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] code);
    logic [DATA_W-1:0] m;
    case (code)
      EW_8:    m = 64'h0000_0000_0000_00ff;
      EW_16:   m = 64'h0000_0000_0000_ffff;
      EW_32:   m = 64'h0000_0000_ffff_ffff;
      EW_64:   m = 64'hffff_ffff_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

endpackage

/* rtl/cas_mem.sv */
// ----------------------------------------------------------------------------
// cas_mem
// Running sum store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cas_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/cas_pos.sv */
// ----------------------------------------------------------------------------
// cas_pos
// Inner and axis position counters of the streamed tensor.
// ----------------------------------------------------------------------------
module cas_pos
  import cas_pkg::*;
#(
  parameter int MAX_INNER = MAX_INNER_DEF,
  parameter int AW        = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  clr,
  input  logic [INNER_W-1:0]    inner_size,
  input  logic [AXIS_LEN_W-1:0] axis_length,
  output logic [AW-1:0]         idx,
  output logic                  first
);

  localparam int CW = ($clog2(MAX_INNER + 1) > INNER_W) ? $clog2(MAX_INNER + 1) : INNER_W;

  logic [AW-1:0]         inner_r, inner_nxt;
  logic [AXIS_POS_W-1:0] axis_r, axis_nxt;
  logic [CW-1:0]         eff_inner, inner_inc, inner_ext;
  logic [AXIS_LEN_W-1:0] eff_axis, axis_inc;

  // clamp the shape to the supported range
  always_comb begin
    inner_ext = CW'(inner_size);
    if (inner_size == '0) begin
      eff_inner = CW'(1);
    end else if (inner_ext > CW'(MAX_INNER)) begin
      eff_inner = CW'(MAX_INNER);
    end else begin
      eff_inner = inner_ext;
    end
    if (axis_length == '0) begin
      eff_axis = AXIS_LEN_W'(1);
    end else if (axis_length > AXIS_LEN_W'(AXIS_MAX)) begin
      eff_axis = AXIS_LEN_W'(AXIS_MAX);
    end else begin
      eff_axis = axis_length;
    end
  end

  // advance inner fastest, then axis
  always_comb begin
    inner_inc = CW'(inner_r) + CW'(1);
    axis_inc  = AXIS_LEN_W'(axis_r) + AXIS_LEN_W'(1);
    inner_nxt = inner_r;
    axis_nxt  = axis_r;
    if (clr) begin
      inner_nxt = '0;
      axis_nxt  = '0;
    end else if (step) begin
      if (inner_inc >= eff_inner) begin
        inner_nxt = '0;
        if (axis_inc >= eff_axis) begin
          axis_nxt = '0;
        end else begin
          axis_nxt = axis_inc[AXIS_POS_W-1:0];
        end
      end else begin
        inner_nxt = inner_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= '0;
      axis_r  <= '0;
    end else begin
      inner_r <= inner_nxt;
      axis_r  <= axis_nxt;
    end
  end

  assign idx   = inner_r;
  assign first = (axis_r == '0);

endmodule

/* rtl/cas_acc.sv */
// ----------------------------------------------------------------------------
// cas_acc
// Accumulate stage and result register, with forwarding of the last write.
// ----------------------------------------------------------------------------
module cas_acc
  import cas_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  acc_ctl_t          ctl,
  input  logic [AW-1:0]     idx,
  input  logic [DATA_W-1:0] value,
  input  logic              excl,
  input  logic [1:0]        wcode,
  input  logic [DATA_W-1:0] rd_data,
  input  logic              out_stall,
  output acc_sts_t          sts,
  output logic [AW-1:0]     wr_addr,
  output logic [DATA_W-1:0] wr_data,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_sum
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [AW-1:0]     s1_idx_r;
  logic              s1_first_r;
  logic [DATA_W-1:0] s1_val_r;
  logic              fwd_r, fwd_nxt;
  logic [DATA_W-1:0] fwd_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_sum_r;

  logic [DATA_W-1:0] mask, prev, v, next_sum, res;
  logic              s1_move;

  // sum of the stored value and the new element
  always_comb begin
    mask     = width_mask(wcode);
    prev     = (fwd_r ? fwd_data_r : rd_data) & mask;
    v        = s1_val_r & mask;
    next_sum = s1_first_r ? v : ((prev + v) & mask);
    if (excl) begin
      res = s1_first_r ? '0 : prev;
    end else begin
      res = next_sum;
    end
  end

  // handshake between stage one and the result register
  always_comb begin
    s1_move       = s1_valid_r && (!out_valid_r || !out_stall);
    s1_valid_nxt  = ctl.take || (s1_valid_r && !s1_move);
    out_valid_nxt = s1_move || (out_valid_r && out_stall);
    fwd_nxt       = fwd_r;
    if (ctl.take) begin
      // the read at this edge misses the write of the same edge
      fwd_nxt = s1_move && (s1_idx_r == idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_r       <= fwd_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      s1_idx_r   <= idx;
      s1_first_r <= ctl.first;
      s1_val_r   <= value;
      fwd_data_r <= next_sum;
    end
    if (s1_move) begin
      out_sum_r <= res;
    end
  end

  assign sts.busy  = s1_valid_r;
  assign sts.stall = s1_valid_r && !s1_move;
  assign sts.wr_en = s1_move;
  assign wr_addr   = s1_idx_r;
  assign wr_data   = next_sum;
  assign out_valid = out_valid_r;
  assign out_sum   = out_sum_r;

endmodule

/* rtl/cumulative_sum_along_axis.sv */
// ----------------------------------------------------------------------------
// cumulative_sum_along_axis
// Streaming cumulative sum of tensor elements along one axis.
// ----------------------------------------------------------------------------
// Usage:
//   Elements enter in row-major order on the in_ channel, one per item, and
//   each gives one item on the out_ channel with the inclusive or exclusive
//   running sum at its position, wrapped to the element width.
//   Configuration is written on the cfg_ channel while the block is idle;
//   cfg_ready is always high. A write of inner_size or axis_length starts a
//   new tensor at position zero.
// Timing:
//   The element is registered in stage one while the running sum is read
//   from the sum memory, then the add result is registered at the output.
//   Throughput is one item per cycle unless a held result stalls stage one;
//   a read of a position written at the same edge gets the forwarded sum.
// Reset:
//   Synchronous active-low reset clears the positions, empties the pipeline
//   and restores the register defaults. The sum memory is not cleared.
// Stall:
//   While out_stall holds a result, the item behind it waits in stage one
//   and in_stall rises only when that stage cannot move on.
// ----------------------------------------------------------------------------
module cumulative_sum_along_axis
  import cas_pkg::*;
#(
  parameter int MAX_INNER = MAX_INNER_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_W-1:0]     in_value_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_W-1:0]     out_sum_out,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

  logic                  excl_r;
  logic [1:0]            wcode_r;
  logic [INNER_W-1:0]    inner_size_r;
  logic [AXIS_LEN_W-1:0] axis_length_r;

  logic                  cfg_we, shape_wr, take;
  logic [AW-1:0]         pos_idx, wr_addr;
  logic                  pos_first;
  logic [DATA_W-1:0]     rd_data, wr_data;
  acc_ctl_t              ctl;
  acc_sts_t              sts;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign shape_wr  = cfg_we && ((cfg_index == REG_INNER) || (cfg_index == REG_AXIS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      excl_r        <= 1'b0;
      wcode_r       <= EW_32;
      inner_size_r  <= INNER_W'(1);
      axis_length_r <= AXIS_LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXCL:  excl_r        <= cfg_data[0];
        REG_WIDTH: wcode_r       <= cfg_data[1:0];
        REG_INNER: inner_size_r  <= cfg_data[INNER_W-1:0];
        REG_AXIS:  axis_length_r <= cfg_data[AXIS_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign in_stall  = sts.stall;
  assign take      = in_valid && !in_stall;
  assign ctl.take  = take;
  assign ctl.first = pos_first;

  cas_pos #(
    .MAX_INNER (MAX_INNER),
    .AW        (AW)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (take),
    .clr         (shape_wr),
    .inner_size  (inner_size_r),
    .axis_length (axis_length_r),
    .idx         (pos_idx),
    .first       (pos_first)
  );

  cas_mem #(
    .DEPTH (MAX_INNER),
    .AW    (AW),
    .DW    (DATA_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (sts.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (take),
    .rd_addr (pos_idx),
    .rd_data (rd_data)
  );

  cas_acc #(
    .AW (AW)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .idx       (pos_idx),
    .value     (in_value_in),
    .excl      (excl_r),
    .wcode     (wcode_r),
    .rd_data   (rd_data),
    .out_stall (out_stall),
    .sts       (sts),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_sum   (out_sum_out)
  );

  // a sum write moves an item into the result register
  a_wr_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    sts.wr_en |=> out_valid)
    else $error("sum written without a result item");

  // stage one only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    sts.stall |-> (sts.busy && out_valid && out_stall))
    else $error("input stalled without a held result");

  // a shape write restarts the tensor
  a_shape_restart: assert property (@(posedge clk) disable iff (!rst_n)
    shape_wr |=> (pos_first && (pos_idx == '0)))
    else $error("position not cleared by shape write");

endmodule

/* test/cas_sum_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_sum_checker
// Watches the element, sum and register channels of the cumulative sum block,
// keeps its own copy of the running sums and compares every sum in order.
// ----------------------------------------------------------------------------
module cas_sum_checker
  import cas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [DATA_W-1:0]     in_value_in,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [DATA_W-1:0]     out_sum_out,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_sums,
  output int                    sums_checked
);

  localparam int SUM_DEPTH    = MAX_INNER_DEF;
  localparam int REPORT_LIMIT = 10;

  // shadow registers
  logic                  excl_q;
  logic [1:0]            width_q;
  logic [INNER_W-1:0]    inner_q;
  logic [AXIS_LEN_W-1:0] axis_q;

  // shadow position and per-column sums
  logic [DATA_W-1:0] column_sums [SUM_DEPTH];
  int                inner_pos;
  int                axis_pos;
  logic [DATA_W-1:0] expected_sums [$];

  // low bits kept at a given element width
  function automatic logic [DATA_W-1:0] lane_mask(input logic [1:0] code);
    int bits;
    bits = 8 << code;
    if (bits >= DATA_W) return '1;
    return (64'd1 << bits) - 64'd1;
  endfunction

  function automatic int inner_span();
    if (inner_q == 0) return 1;
    if (inner_q > SUM_DEPTH) return SUM_DEPTH;
    return int'(inner_q);
  endfunction

  function automatic int axis_span();
    if (axis_q == 0) return 1;
    if (axis_q > AXIS_MAX) return AXIS_MAX;
    return int'(axis_q);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endtask

  // expected sum for one element, then step the position
  task automatic predict_sum(input logic [DATA_W-1:0] element);
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] prev;
    logic [DATA_W-1:0] total;
    logic [DATA_W-1:0] sum_val;
    m = lane_mask(width_q);
    v = element & m;
    if (axis_pos == 0) begin
      column_sums[inner_pos] = v;
      sum_val = excl_q ? '0 : v;
    end else begin
      prev  = column_sums[inner_pos] & m;
      total = (prev + v) & m;
      column_sums[inner_pos] = total;
      sum_val = excl_q ? prev : total;
    end
    expected_sums.push_back(sum_val & m);
    inner_pos++;
    if (inner_pos >= inner_span()) begin
      inner_pos = 0;
      axis_pos++;
      if (axis_pos >= axis_span()) axis_pos = 0;
    end
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_EXCL:  excl_q = data[0];
      REG_WIDTH: width_q = data[1:0];
      REG_INNER: begin
        inner_q   = data[INNER_W-1:0];
        inner_pos = 0;
        axis_pos  = 0;
      end
      REG_AXIS: begin
        axis_q    = data[AXIS_LEN_W-1:0];
        inner_pos = 0;
        axis_pos  = 0;
      end
      default: ;
    endcase
  endtask

  // sample all three channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      excl_q    = 1'b0;
      width_q   = EW_32;
      inner_q   = INNER_W'(1);
      axis_q    = AXIS_LEN_W'(1);
      inner_pos = 0;
      axis_pos  = 0;
      expected_sums.delete();
    end else begin
      // compare the sum leaving the block
      if (out_valid && !out_stall) begin
        if (expected_sums.size() == 0) begin
          note_failure($sformatf("sum with no element pending: got %h", out_sum_out));
        end else begin
          sums_checked++;
          if (out_sum_out !== expected_sums[0]) begin
            note_failure($sformatf("sum mismatch: expected %h got %h",
                                   expected_sums[0], out_sum_out));
          end
          void'(expected_sums.pop_front());
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) predict_sum(in_value_in);
    end
    pending_sums = expected_sums.size();
  end

endmodule

/* test/cumulative_sum_along_axis_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cumulative_sum_along_axis_tb
// Streams elements through the cumulative sum block under a series of shapes,
// modes and element widths, with random gaps and output stalls, while the
// checker compares every sum against its own running model.
// ----------------------------------------------------------------------------
module cumulative_sum_along_axis_tb;
  import cas_pkg::*;

  localparam int RANDOM_ITEMS    = 700;
  localparam int CALM_TAIL       = 100;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int SETTLE_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT  = 1000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DATA_W-1:0]     in_value_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DATA_W-1:0]     out_sum_out;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending_sums;
  int sums_checked;
  int quiet_cycles = 0;
  int elements_sent = 0;
  int reg_writes = 0;
  bit idling_on = 1'b0;
  bit hold_off_req = 1'b0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cumulative_sum_along_axis u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_value_in (in_value_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sum_out (out_sum_out),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  cas_sum_checker u_sum_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value_in  (in_value_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sum_out  (out_sum_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending_sums (pending_sums),
    .sums_checked (sums_checked)
  );

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // sum receiver: random stall bursts and one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one element, return at the falling edge after it is taken
  task automatic send_item(input logic [DATA_W-1:0] value);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_value_in <= value;
    do @(posedge clk); while (in_stall);
    elements_sent++;
    @(negedge clk);
  endtask

  // stop offering and let every pending sum come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_sums != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // mode and width with junk in the unused data bits
  task automatic set_mode(input logic excl, input logic [1:0] code);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_EXCL, {junk[CFG_DATA_W-1:1], excl});
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_WIDTH, {junk[CFG_DATA_W-1:2], code});
  endtask

  task automatic configure(input logic excl, input logic [1:0] code,
                           input int inner_val, input int axis_val);
    logic [CFG_DATA_W-1:0] junk;
    logic [INNER_W-1:0]    inner_bits;
    set_mode(excl, code);
    junk = CFG_DATA_W'($urandom);
    inner_bits = INNER_W'(inner_val);
    write_reg(REG_INNER, {junk[CFG_DATA_W-1:INNER_W], inner_bits});
    write_reg(REG_AXIS, CFG_DATA_W'(axis_val));
  endtask

  function automatic logic [DATA_W-1:0] random_element();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return DATA_W'($urandom_range(0, 3));
      3:       return {32'hffff_ffff, $urandom} ^ {$urandom_range(0, 255), 32'h0};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // stimulus
  initial begin
    int random_sent;
    int inner_val;
    int axis_val;
    int inner_eff;
    int phase_len;
    bit hold_done;
    random_sent = 0;
    hold_done = 1'b0;
    inner_eff = 1;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // register defaults: inclusive, 32 bit, every element its own slice
    send_item('0);
    send_item('1);
    send_item(64'ha5a5_5a5a_0f0f_f0f0);
    wait_idle();

    // 8 bit wrap over a full 2 x 3 tensor
    configure(1'b0, EW_8, 2, 3);
    send_item(64'hff);
    send_item(64'hff);
    send_item(64'h01);
    send_item(64'h80);
    send_item(64'hffff_ffff_ffff_ff7f);
    send_item('0);
    wait_idle();

    // exclusive 64 bit wrap
    configure(1'b1, EW_64, 1, 3);
    send_item('1);
    send_item('1);
    send_item(64'h1);
    wait_idle();

    // zero inner size and zero axis length act as one
    configure(1'b1, EW_64, 0, 0);
    send_item({$urandom, $urandom});
    send_item('1);
    wait_idle();

    // mode and width change in the middle of a column
    configure(1'b0, EW_16, 1, 4);
    send_item(64'h0000_0000_0001_ffff);
    send_item(64'h8000);
    wait_idle();
    set_mode(1'b1, EW_8);
    send_item(64'hff);
    send_item(64'h01);
    wait_idle();

    // oversized shape clamps to the largest sizes
    configure(1'b0, EW_32, 2047, 131071);
    send_item('1);
    send_item(64'hffff_ffff);
    send_item({$urandom, $urandom});
    wait_idle();

    // random phases, mostly small shapes walked through whole slices
    idling_on = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent >= RANDOM_ITEMS - CALM_TAIL) idling_on = 1'b0;
      if (random_sent == 0 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 19))
          0:       inner_val = 0;
          1:       inner_val = $urandom_range(MAX_INNER_DEF + 1, 2047);
          2:       inner_val = MAX_INNER_DEF;
          3:       inner_val = $urandom_range(65, 100);
          default: inner_val = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 11))
          0:       axis_val = 0;
          1:       axis_val = AXIS_MAX;
          2:       axis_val = $urandom_range(AXIS_MAX + 1, 131071);
          default: axis_val = $urandom_range(1, 6);
        endcase
        configure(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  inner_val, axis_val);
        inner_eff = (inner_val == 0) ? 1 :
                    (inner_val > MAX_INNER_DEF) ? MAX_INNER_DEF : inner_val;
      end else begin
        set_mode(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      end
      if (inner_eff >= MAX_INNER_DEF) phase_len = $urandom_range(20, 40);
      else if (inner_eff > 64) phase_len = inner_eff + $urandom_range(4, 16);
      else phase_len = $urandom_range(8, 50);
      if (!hold_done && random_sent >= 200) begin
        hold_off_req = 1'b1;
        hold_done = 1'b1;
      end
      repeat (phase_len) begin
        send_item(random_element());
        random_sent++;
      end
      wait_idle();
    end

    $display("run: %0d elements in, %0d sums compared, %0d register writes",
             elements_sent, sums_checked, reg_writes);
    $display("covered both modes, 8 to 64 bit lanes, clamped shapes, %0d-cycle hold-off",
             HOLD_OFF_CYCLES);
    if (fail_count == 0 && pending_sums == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/cas_pkg.sv
rtl/cas_mem.sv
rtl/cas_pos.sv
rtl/cas_acc.sv
rtl/cumulative_sum_along_axis.sv
test/cas_sum_checker.sv
test/cumulative_sum_along_axis_tb.sv
